FILE: hdl/amde_pkg.sv
// Shared types and constants for the advertising manufacturer data extractor.
// Holds the walk phase encoding, status codes and the result record.
// No dependencies.
package amde_pkg;

    localparam int DATA_W   = 8;
    localparam int CFG_W    = 16;
    localparam int STATUS_W = 2;
    localparam int M_DATA_W = 16;

    localparam logic [DATA_W-1:0] ADDR_BYTES = 8'd6;
    localparam logic [DATA_W-1:0] MIN_LEN    = 8'd6;
    localparam logic [DATA_W-1:0] MIN_STRUCT = 8'd3;

    localparam logic [CFG_W-1:0]  COMPANY_ID_RESET = 16'h0059;
    localparam logic [DATA_W-1:0] MATCH_TYPE_RESET = 8'hFF;

    localparam logic CFG_COMPANY_ID = 1'b0;
    localparam logic CFG_MATCH_TYPE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_PAYLOAD = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOMATCH = 2'd2;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LEN,
        PH_SLEN,
        PH_TYPE,
        PH_IDLO,
        PH_IDHI,
        PH_SKIP,
        PH_PAYLOAD
    } phase_t;

    typedef struct packed {
        logic                last;
        logic [STATUS_W-1:0] status;
        logic [DATA_W-1:0]   payload;
    } result_t;

endpackage

FILE: hdl/adv_manufacturer_data_extractor_core.sv
// Advertising manufacturer data extractor, top level.
// Walks the AD structures of a received packet and streams the matching payload.
// Depends on amde_pkg.
//
// Usage:
//   s_* carries packet bytes: tdata is the byte, tuser marks the header byte
//   that opens a packet. m_* carries results: tdata holds the payload byte and
//   the status code, tlast flags the final result of a packet.
//   cfg_we/cfg_index/cfg_data write company_id (index 0) or match_type
//   (index 1); write only while no packet is being walked.
// Timing:
//   One request is taken every cycle while s_tready is high. A result is
//   captured in the result register, or in the skid stage while that register
//   is held; the walk state updates at the edge that takes the request. The
//   one-entry skid stage decouples the sides: when the receiver stalls, one more
//   result is absorbed and s_tready drops until the skid stage drains.
// Reset:
//   Clears the walk to idle and both output stages to empty; company_id
//   returns to 0x0059 and match_type to 0xFF. Bytes without a header mark
//   are dropped while idle.
module adv_manufacturer_data_extractor_core
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [amde_pkg::DATA_W-1:0]  s_tdata,   // [7:0] data_byte
    input  logic                         s_tuser,   // [0] first
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [amde_pkg::M_DATA_W-1:0] m_tdata,  // [7:0] payload_byte, [9:8] status
    output logic                         m_tlast,
    input  logic                         cfg_we,
    input  logic                         cfg_index,
    input  logic [amde_pkg::CFG_W-1:0]   cfg_data
);
    import amde_pkg::*;

    logic [CFG_W-1:0]  company_id_reg;
    logic [DATA_W-1:0] match_type_reg;

    phase_t            phase_reg, phase_next;
    logic [DATA_W-1:0] ad_rem_reg, ad_rem_next;
    logic [DATA_W-1:0] slen_reg, slen_next;
    logic [DATA_W-1:0] soff_reg, soff_next;
    logic [DATA_W-1:0] id_lo_reg, id_lo_next;

    logic              out_valid_reg;
    result_t           out_reg;
    logic              skid_valid_reg;
    result_t           skid_reg;

    logic              accept;
    logic              out_take;
    logic [DATA_W-1:0] v;
    logic [DATA_W-1:0] off_inc;
    logic              fdone;
    logic [DATA_W:0]   need;
    logic              res_valid;
    result_t           res;

    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign out_take = out_valid_reg && m_tready;
    assign v        = s_tdata;
    assign off_inc  = soff_reg + 8'd1;
    assign fdone    = (off_inc >= slen_reg);
    assign need     = {1'b0, v} + 9'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            company_id_reg <= COMPANY_ID_RESET;
            match_type_reg <= MATCH_TYPE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_COMPANY_ID: company_id_reg <= cfg_data;
                CFG_MATCH_TYPE: match_type_reg <= cfg_data[DATA_W-1:0];
                default:        company_id_reg <= company_id_reg;
            endcase
        end
    end

    // next state of the walk
    always_comb
    begin
        phase_next  = phase_reg;
        ad_rem_next = ad_rem_reg;
        slen_next   = slen_reg;
        soff_next   = soff_reg;
        id_lo_next  = id_lo_reg;
        if (accept)
        begin
            if (s_tuser)
            begin
                phase_next  = PH_LEN;
                ad_rem_next = '0;
                slen_next   = '0;
                soff_next   = '0;
                id_lo_next  = '0;
            end
            else
            begin
                case (phase_reg)
                    PH_IDLE:
                    begin
                        phase_next = PH_IDLE;
                    end
                    PH_LEN:
                    begin
                        if (v < MIN_LEN)
                        begin
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            ad_rem_next = v - MIN_LEN;
                            slen_next   = ADDR_BYTES;
                            soff_next   = '0;
                            phase_next  = PH_SKIP;
                        end
                    end
                    PH_SLEN:
                    begin
                        if (v == '0 || need > {1'b0, ad_rem_reg})
                        begin
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            ad_rem_next = ad_rem_reg - need[DATA_W-1:0];
                            slen_next   = v;
                            soff_next   = '0;
                            phase_next  = PH_TYPE;
                        end
                    end
                    PH_TYPE:
                    begin
                        soff_next = off_inc;
                        if (v == match_type_reg && slen_reg >= MIN_STRUCT)
                            phase_next = PH_IDLO;
                        else if (fdone)
                            phase_next = (ad_rem_reg == '0) ? PH_IDLE : PH_SLEN;
                        else
                            phase_next = PH_SKIP;
                    end
                    PH_IDLO:
                    begin
                        soff_next  = off_inc;
                        id_lo_next = v;
                        phase_next = PH_IDHI;
                    end
                    PH_IDHI:
                    begin
                        soff_next = off_inc;
                        if ({v, id_lo_reg} == company_id_reg)
                            phase_next = fdone ? PH_IDLE : PH_PAYLOAD;
                        else if (fdone)
                            phase_next = (ad_rem_reg == '0) ? PH_IDLE : PH_SLEN;
                        else
                            phase_next = PH_SKIP;
                    end
                    PH_PAYLOAD:
                    begin
                        soff_next = off_inc;
                        if (fdone)
                            phase_next = PH_IDLE;
                    end
                    PH_SKIP:
                    begin
                        soff_next = off_inc;
                        if (fdone)
                            phase_next = (ad_rem_reg == '0) ? PH_IDLE : PH_SLEN;
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    // result of the accepted byte
    always_comb
    begin
        res_valid   = 1'b0;
        res.payload = '0;
        res.status  = ST_NOMATCH;
        res.last    = 1'b1;
        if (accept)
        begin
            if (s_tuser)
            begin
                res_valid = (phase_reg != PH_IDLE);
            end
            else
            begin
                case (phase_reg)
                    PH_LEN:
                    begin
                        res_valid = (v < MIN_LEN);
                    end
                    PH_SLEN:
                    begin
                        res_valid = (v == '0 || need > {1'b0, ad_rem_reg});
                    end
                    PH_TYPE:
                    begin
                        res_valid = !(v == match_type_reg && slen_reg >= MIN_STRUCT)
                                    && fdone && (ad_rem_reg == '0);
                    end
                    PH_IDHI:
                    begin
                        if ({v, id_lo_reg} == company_id_reg)
                        begin
                            res_valid  = fdone;
                            res.status = ST_EMPTY;
                        end
                        else
                        begin
                            res_valid = fdone && (ad_rem_reg == '0);
                        end
                    end
                    PH_PAYLOAD:
                    begin
                        res_valid   = 1'b1;
                        res.payload = v;
                        res.status  = ST_PAYLOAD;
                        res.last    = fdone;
                    end
                    PH_SKIP:
                    begin
                        res_valid = fdone && (ad_rem_reg == '0);
                    end
                    default:
                    begin
                        res_valid = 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            ad_rem_reg <= '0;
            slen_reg   <= '0;
            soff_reg   <= '0;
            id_lo_reg  <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            ad_rem_reg <= ad_rem_next;
            slen_reg   <= slen_next;
            soff_reg   <= soff_next;
            id_lo_reg  <= id_lo_next;
        end
    end

    // hold results in the output register, overflow into the skid stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_take)
                skid_valid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            if (!out_valid_reg || out_take)
                out_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
        else if (out_take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
                out_reg <= skid_reg;
        end
        else if (res_valid)
        begin
            if (!out_valid_reg || out_take)
                out_reg <= res;
            else
                skid_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_DATA_W-DATA_W-STATUS_W){1'b0}}, out_reg.status, out_reg.payload};
    assign m_tlast  = out_reg.last;

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage full while output register empty");

    a_idle_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !s_tuser && phase_reg == PH_IDLE) |-> !res_valid)
        else $error("result produced for a byte outside a packet");

    a_last_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.last && !s_tuser) |=> phase_reg == PH_IDLE)
        else $error("walk still active after final result");

    a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.status == ST_PAYLOAD || out_reg.status == ST_EMPTY
                           || out_reg.status == ST_NOMATCH))
        else $error("illegal status code on output");

    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.status != ST_PAYLOAD) |-> out_reg.last)
        else $error("status result not flagged as last");

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for adv_manufacturer_data_extractor_core: packet streams in,
// predicted payload/status results compared against the result stream.
// Depends on amde_pkg and the core RTL.

import amde_pkg::*;

class mfr_data_scoreboard;

    logic [CFG_W-1:0]  company_id;
    logic [DATA_W-1:0] match_type;
    logic [8:0]        byte_pos;
    logic [7:0]        remaining;
    logic [7:0]        field_len;
    logic [7:0]        field_off;
    logic [7:0]        id_low;
    phase_t            walk;
    logic              answered;
    result_t           expected_results[$];
    int                errors;

    function new();
        company_id = COMPANY_ID_RESET;
        match_type = MATCH_TYPE_RESET;
        byte_pos   = '0;
        remaining  = '0;
        field_len  = '0;
        field_off  = '0;
        id_low     = '0;
        walk       = PH_IDLE;
        answered   = 1'b1;
        errors     = 0;
    endfunction

    function void set_reg(logic idx, logic [CFG_W-1:0] value);
        if (idx == CFG_COMPANY_ID)
            company_id = value;
        else
            match_type = value[DATA_W-1:0];
    endfunction

    function void emit_result(logic [7:0] payload, logic [STATUS_W-1:0] status, logic last);
        result_t r;
        r.payload = payload;
        r.status  = status;
        r.last    = last;
        expected_results.push_back(r);
    endfunction

    function void close_packet(logic [STATUS_W-1:0] status);
        walk     = PH_IDLE;
        answered = 1'b1;
        emit_result(8'h00, status, 1'b1);
    endfunction

    function void end_of_field();
        if (remaining == 8'd0)
            close_packet(ST_NOMATCH);
        else
            walk = PH_SLEN;
    endfunction

    function void note_request(logic [7:0] v, logic first);
        if (first)
        begin
            // abandon an unanswered packet
            if (!answered)
                emit_result(8'h00, ST_NOMATCH, 1'b1);
            answered  = 1'b0;
            walk      = PH_LEN;
            byte_pos  = 9'd1;
            remaining = '0;
            field_len = '0;
            field_off = '0;
            id_low    = '0;
            return;
        end
        if (walk == PH_IDLE)
            return;
        if (byte_pos < 9'd511)
            byte_pos++;
        case (walk)
            PH_LEN:
            begin
                if (v < MIN_LEN)
                    close_packet(ST_NOMATCH);
                else
                begin
                    remaining = v - MIN_LEN;
                    field_len = ADDR_BYTES;
                    field_off = '0;
                    walk      = PH_SKIP;
                end
            end
            PH_SLEN:
            begin
                if (v == 8'd0 || ({1'b0, v} + 9'd1) > {1'b0, remaining})
                    close_packet(ST_NOMATCH);
                else
                begin
                    remaining = remaining - v - 8'd1;
                    field_len = v;
                    field_off = '0;
                    walk      = PH_TYPE;
                end
            end
            PH_TYPE:
            begin
                field_off++;
                if (v == match_type && field_len >= MIN_STRUCT)
                    walk = PH_IDLO;
                else if (field_off >= field_len)
                    end_of_field();
                else
                    walk = PH_SKIP;
            end
            PH_IDLO:
            begin
                field_off++;
                id_low = v;
                walk   = PH_IDHI;
            end
            PH_IDHI:
            begin
                field_off++;
                if ({v, id_low} == company_id)
                begin
                    if (field_off >= field_len)
                        close_packet(ST_EMPTY);
                    else
                        walk = PH_PAYLOAD;
                end
                else if (field_off >= field_len)
                    end_of_field();
                else
                    walk = PH_SKIP;
            end
            PH_PAYLOAD:
            begin
                field_off++;
                if (field_off >= field_len)
                begin
                    walk     = PH_IDLE;
                    answered = 1'b1;
                    emit_result(v, ST_PAYLOAD, 1'b1);
                end
                else
                    emit_result(v, ST_PAYLOAD, 1'b0);
            end
            PH_SKIP:
            begin
                field_off++;
                if (field_off >= field_len)
                    end_of_field();
            end
            default:
            begin
            end
        endcase
    endfunction

    function void check_result(logic [7:0] payload, logic [STATUS_W-1:0] status, logic last);
        result_t want;
        if (expected_results.size() == 0)
        begin
            $error("unexpected result: payload_byte %0h status %0d last %0b",
                   payload, status, last);
            errors++;
            return;
        end
        want = expected_results.pop_front();
        if (payload !== want.payload)
        begin
            $error("payload_byte expected %0h actual %0h", want.payload, payload);
            errors++;
        end
        if (status !== want.status)
        begin
            $error("status expected %0d actual %0d", want.status, status);
            errors++;
        end
        if (last !== want.last)
        begin
            $error("last expected %0b actual %0b", want.last, last);
            errors++;
        end
    endfunction

endclass

module testbench;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int PHASE_COUNT     = 6;
    localparam int BYTES_PER_PHASE = 320;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [DATA_W-1:0]    s_tdata   = '0;
    logic                 s_tuser   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_DATA_W-1:0]  m_tdata;
    logic                 m_tlast;
    logic                 cfg_we    = 1'b0;
    logic                 cfg_index = 1'b0;
    logic [CFG_W-1:0]     cfg_data  = '0;

    mfr_data_scoreboard   sb;
    int                   idle_pct = 37;
    int                   cycle_count = 0;
    logic [8:0]           pkt_q[$];

    adv_manufacturer_data_extractor_core dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= idle_pct);

    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata[7:0], m_tdata[9:8], m_tlast);

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL adv_manufacturer_data_extractor_core");
        $finish;
    end

    task automatic send_byte(input logic [7:0] data, input logic first);
        while ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= first;
        do @(posedge clk); while (!s_tready);
        sb.note_request(data, first);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        sb.set_reg(idx, value);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    // close any open packet with zero bytes, then drain the results
    task automatic wait_quiet();
        while (!sb.answered)
            send_byte(8'h00, 1'b0);
        s_tvalid <= 1'b0;
        do @(posedge clk); while (sb.expected_results.size() != 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic build_packet();
        logic [7:0]  region[$];
        logic [15:0] cid;
        int          mode;
        int          nstruct;
        int          slen;
        int          len_byte;
        int          cut;
        pkt_q.delete();
        mode = $urandom_range(99);
        pkt_q.push_back({1'b1, 8'($urandom)});
        if (mode < 5)
        begin
            pkt_q.push_back({1'b0, 8'($urandom_range(MIN_LEN - 1))});
            return;
        end
        if (mode < 10)
        begin
            pkt_q.push_back({1'b0, 8'($urandom)});
            repeat ($urandom_range(1, 40))
                pkt_q.push_back({1'b0, 8'($urandom)});
            return;
        end
        nstruct = $urandom_range(0, 4);
        for (int s = 0; s < nstruct; s++)
        begin
            slen = ($urandom_range(7) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 10);
            if (mode < 15 && $urandom_range(2) == 0)
                slen = 0;
            region.push_back(8'(slen));
            cid = ($urandom_range(99) < 55) ? sb.company_id : 16'($urandom);
            for (int i = 0; i < slen; i++)
            begin
                case (i)
                    0:       region.push_back(($urandom_range(99) < 60) ? sb.match_type
                                                                         : 8'($urandom));
                    1:       region.push_back(cid[7:0]);
                    2:       region.push_back(cid[15:8]);
                    default: region.push_back(8'($urandom));
                endcase
            end
        end
        len_byte = MIN_LEN + region.size();
        if (mode >= 15 && mode < 22)
        begin
            cut = $urandom_range(1, 3);
            len_byte = (len_byte - cut < MIN_LEN) ? MIN_LEN : len_byte - cut;
        end
        else if (mode >= 22 && mode < 27)
            len_byte = len_byte + $urandom_range(1, 4);
        pkt_q.push_back({1'b0, 8'(len_byte)});
        repeat (ADDR_BYTES)
            pkt_q.push_back({1'b0, 8'($urandom)});
        foreach (region[i])
            pkt_q.push_back({1'b0, region[i]});
        if (mode >= 27 && mode < 32)
            repeat ($urandom_range(1, pkt_q.size() - 1))
                void'(pkt_q.pop_back());
    endtask

    task automatic send_packet();
        int pause_at;
        pause_at = ($urandom_range(29) == 0) ? $urandom_range(pkt_q.size() - 1) : -1;
        foreach (pkt_q[i])
        begin
            // hold the stream until every pending result is out
            if (i == pause_at)
            begin
                s_tvalid <= 1'b0;
                do @(posedge clk); while (sb.expected_results.size() != 0);
            end
            send_byte(pkt_q[i][7:0], pkt_q[i][8]);
        end
    endtask

    initial
    begin
        logic [CFG_W-1:0]  cid;
        logic [DATA_W-1:0] mt;
        int                sent;
        sb = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h5A, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hA5, 1'b1);
        send_byte(8'h0A, 1'b0);
        repeat (3)
        begin
            send_byte(8'h00, 1'b0);
            send_byte(8'hFF, 1'b0);
        end
        send_byte(8'h03, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h59, 1'b0);
        send_byte(8'h00, 1'b0);

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            wait_quiet();
            case (p)
                0:       begin cid = 16'h0000; mt = 8'h00; end
                1:       begin cid = 16'hFFFF; mt = 8'hFF; end
                3:       begin cid = COMPANY_ID_RESET; mt = MATCH_TYPE_RESET; end
                5:       begin cid = 16'hFFFF; mt = 8'h00; end
                default: begin cid = 16'($urandom); mt = 8'($urandom); end
            endcase
            write_reg(CFG_COMPANY_ID, cid);
            write_reg(CFG_MATCH_TYPE, {8'($urandom), mt});
            idle_pct = (p == 1) ? 0 : 37;
            sent = 0;
            while (sent < BYTES_PER_PHASE)
            begin
                build_packet();
                send_packet();
                sent += pkt_q.size();
                if ($urandom_range(19) == 0)
                    repeat ($urandom_range(1, 3))
                        send_byte(8'($urandom), 1'b0);
            end
        end

        s_tvalid <= 1'b0;
        do @(posedge clk); while (sb.expected_results.size() != 0);
        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.expected_results.size() == 0)
            $display("PASS adv_manufacturer_data_extractor_core");
        else
            $display("FAIL adv_manufacturer_data_extractor_core");
        $finish;
    end

endmodule
